// File: sv/rxrf_pkg.sv
// shared constants, codes, types and token tables for the receive ring framer
package rxrf_pkg;

    localparam int RING_DEPTH = 2048;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int LINE_MAX   = 63;
    localparam int CNT_W      = 6;

    localparam logic [7:0] CHAR_LT = 8'h3C;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [2:0] {
        KIND_STORED       = 3'd0,
        KIND_DROPPED      = 3'd1,
        KIND_IDLE         = 3'd2,
        KIND_CONNECTED    = 3'd3,
        KIND_DISCONNECTED = 3'd4,
        KIND_DISCARDED    = 3'd5,
        KIND_LINE_BYTE    = 3'd6
    } kind_t;

    typedef enum logic [0:0] {
        OP_STORE = 1'b0,
        OP_POLL  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FINISH,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic store;
        logic scan_ev;
        logic finish;
        logic emit_out;
    } cmd_t;

    typedef struct packed {
        logic is_poll;
        logic scan_empty;
        logic tok_hit;
        logic need_emit;
        logic emit_last;
    } status_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
        ring_next = (i == PTR_W'(RING_DEPTH - 1)) ? '0 : i + PTR_W'(1);
    endfunction

    // index of the final token byte: connect when idle, disconnect when up
    function automatic logic [3:0] tok_last(input logic sess);
        tok_last = sess ? 4'd11 : 4'd8;
    endfunction

    function automatic logic [7:0] tok_byte(input logic sess, input logic [3:0] m);
        logic [7:0] b;
        b = 8'h00;
        if (!sess) begin
            unique case (m)
                4'd0:    b = 8'h3C;
                4'd1:    b = 8'h43;
                4'd2:    b = 8'h4F;
                4'd3:    b = 8'h4E;
                4'd4:    b = 8'h4E;
                4'd5:    b = 8'h45;
                4'd6:    b = 8'h43;
                4'd7:    b = 8'h54;
                4'd8:    b = 8'h3E;
                default: b = 8'h00;
            endcase
        end else begin
            unique case (m)
                4'd0:    b = 8'h3C;
                4'd1:    b = 8'h44;
                4'd2:    b = 8'h49;
                4'd3:    b = 8'h53;
                4'd4:    b = 8'h43;
                4'd5:    b = 8'h4F;
                4'd6:    b = 8'h4E;
                4'd7:    b = 8'h4E;
                4'd8:    b = 8'h45;
                4'd9:    b = 8'h43;
                4'd10:   b = 8'h54;
                4'd11:   b = 8'h3E;
                default: b = 8'h00;
            endcase
        end
        tok_byte = b;
    endfunction

endpackage

// File: sv/rx_ring_line_and_token_framer_core.sv
// top level of the receive ring with line framing and connect/disconnect session
//
// A transaction is taken when start is high and busy is low. Results appear on
// kind, line_byte, last and session_up for exactly one cycle, flagged by
// strobe; the receiver cannot stall them, so it must take every strobe. A
// store latches the byte when it is accepted, then writes the ring and loads
// its result in the store state. A poll reads the 2048-entry ring from the
// read pointer up to the write pointer (stopping early on a full token), each
// byte through a read state and an evaluate state, since the ring memory has a
// single registered read port; an emitted line then takes each output byte,
// at most 63, through an emit read state and an emit output state.
// busy stays high until the final result is loaded and drops while that
// result is on the ports.
module rx_ring_line_and_token_framer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    output logic       busy,
    output logic       strobe,
    output logic [2:0] kind,
    output logic [7:0] line_byte,
    output logic       last,
    output logic       session_up
);

    rxrf_pkg::cmd_t    cmd;
    rxrf_pkg::status_t status;

    rxrf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rxrf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (opcode),
        .rx_byte    (rx_byte),
        .status     (status),
        .strobe     (strobe),
        .kind       (kind),
        .line_byte  (line_byte),
        .last       (last),
        .session_up (session_up)
    );

endmodule

// File: sv/rxrf_ctrl.sv
// session step sequencer: issues datapath commands per transaction
module rxrf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rxrf_pkg::status_t status,
    output rxrf_pkg::cmd_t    cmd,
    output logic              busy
);

    rxrf_pkg::state_t state_reg;
    rxrf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rxrf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            rxrf_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = rxrf_pkg::ST_STORE;
                end
            end
            rxrf_pkg::ST_STORE:
            begin
                // the latched opcode decides between a store and a poll
                if (status.is_poll)
                begin
                    state_next = rxrf_pkg::ST_SCAN_RD;
                end
                else
                begin
                    cmd.store  = 1'b1;
                    state_next = rxrf_pkg::ST_IDLE;
                end
            end
            rxrf_pkg::ST_SCAN_RD:
            begin
                state_next = status.scan_empty ? rxrf_pkg::ST_FINISH : rxrf_pkg::ST_SCAN_EV;
            end
            rxrf_pkg::ST_SCAN_EV:
            begin
                cmd.scan_ev = 1'b1;
                state_next  = status.tok_hit ? rxrf_pkg::ST_FINISH : rxrf_pkg::ST_SCAN_RD;
            end
            rxrf_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = status.need_emit ? rxrf_pkg::ST_EMIT_RD : rxrf_pkg::ST_IDLE;
            end
            rxrf_pkg::ST_EMIT_RD:
            begin
                state_next = rxrf_pkg::ST_EMIT_OUT;
            end
            rxrf_pkg::ST_EMIT_OUT:
            begin
                cmd.emit_out = 1'b1;
                state_next   = status.emit_last ? rxrf_pkg::ST_IDLE : rxrf_pkg::ST_EMIT_RD;
            end
            default:
            begin
                state_next = rxrf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/rxrf_datapath.sv
// ring memory, pointers, token matcher, line-end finder and result registers
module rxrf_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rxrf_pkg::cmd_t    cmd,
    input  logic              opcode,
    input  logic [7:0]        rx_byte,
    output rxrf_pkg::status_t status,
    output logic              strobe,
    output logic [2:0]        kind,
    output logic [7:0]        line_byte,
    output logic              last,
    output logic              session_up
);

    localparam int PW = rxrf_pkg::PTR_W;
    localparam int CW = rxrf_pkg::CNT_W;

    logic [7:0]    ring_mem [rxrf_pkg::RING_DEPTH];
    logic [7:0]    rd_data_reg;

    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic          session_reg;

    logic          opcode_reg;
    logic [7:0]    byte_reg;

    logic [PW-1:0] idx_reg;
    logic [3:0]    match_reg;
    logic          prev_cr_reg;
    logic          tok_found_reg;
    logic [PW-1:0] tok_end_reg;
    logic          eol_found_reg;
    logic [PW-1:0] eol_reg;
    logic [CW-1:0] n_reg;

    logic          strobe_reg;
    logic [2:0]    kind_reg;
    logic [7:0]    line_byte_reg;
    logic          last_reg;
    logic          session_up_reg;

    logic [PW-1:0] idx_succ;
    logic          ring_full;
    logic          tok_match;
    logic          tok_hit;
    logic          line_hit;
    logic          need_emit;
    logic          emit_last;

    assign idx_succ  = rxrf_pkg::ring_next(idx_reg);
    assign ring_full = (rxrf_pkg::ring_next(wp_reg) == rp_reg);
    assign tok_match = (rd_data_reg == rxrf_pkg::tok_byte(session_reg, match_reg));
    assign tok_hit   = tok_match && (match_reg == rxrf_pkg::tok_last(session_reg));
    assign line_hit  = (rd_data_reg == rxrf_pkg::CHAR_LF) && prev_cr_reg && !eol_found_reg;
    assign need_emit = !tok_found_reg && eol_found_reg && session_reg;
    assign emit_last = (idx_reg == eol_reg) || (n_reg == CW'(rxrf_pkg::LINE_MAX - 1));

    assign status.is_poll    = (opcode_reg == rxrf_pkg::OP_POLL);
    assign status.scan_empty = (idx_reg == wp_reg);
    assign status.tok_hit    = tok_hit;
    assign status.need_emit  = need_emit;
    assign status.emit_last  = emit_last;

    // ring store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store && !ring_full)
        begin
            ring_mem[wp_reg] <= byte_reg;
        end
        rd_data_reg <= ring_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            session_reg   <= 1'b0;
            opcode_reg    <= 1'b0;
            idx_reg       <= '0;
            match_reg     <= '0;
            prev_cr_reg   <= 1'b0;
            tok_found_reg <= 1'b0;
            tok_end_reg   <= '0;
            eol_found_reg <= 1'b0;
            eol_reg       <= '0;
            n_reg         <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                opcode_reg    <= opcode;
                idx_reg       <= rp_reg;
                match_reg     <= '0;
                prev_cr_reg   <= 1'b0;
                tok_found_reg <= 1'b0;
                eol_found_reg <= 1'b0;
            end
            if (cmd.store && !ring_full)
            begin
                wp_reg <= rxrf_pkg::ring_next(wp_reg);
            end
            if (cmd.scan_ev)
            begin
                idx_reg     <= idx_succ;
                prev_cr_reg <= (rd_data_reg == rxrf_pkg::CHAR_CR);
                if (tok_match)
                begin
                    match_reg <= match_reg + 4'd1;
                end
                else
                begin
                    // restart, counting a '<' as the first token byte
                    match_reg <= (rd_data_reg == rxrf_pkg::CHAR_LT) ? 4'd1 : 4'd0;
                end
                if (tok_hit)
                begin
                    tok_found_reg <= 1'b1;
                    tok_end_reg   <= idx_succ;
                end
                if (line_hit)
                begin
                    eol_found_reg <= 1'b1;
                    eol_reg       <= idx_reg;
                end
            end
            if (cmd.finish)
            begin
                priority if (tok_found_reg)
                begin
                    rp_reg      <= tok_end_reg;
                    session_reg <= !session_reg;
                end
                else if (eol_found_reg && !session_reg)
                begin
                    rp_reg <= rxrf_pkg::ring_next(eol_reg);
                end
                else if (need_emit)
                begin
                    idx_reg <= rp_reg;
                    n_reg   <= '0;
                end
            end
            if (cmd.emit_out)
            begin
                idx_reg <= idx_succ;
                n_reg   <= n_reg + CW'(1);
                if (emit_last)
                begin
                    rp_reg <= rxrf_pkg::ring_next(eol_reg);
                end
            end
        end
    end

    // result registers, with a one-cycle strobe per result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.store || (cmd.finish && !need_emit) || cmd.emit_out;
        end
    end

    always_ff @(posedge clk)
    begin
        line_byte_reg  <= 8'h00;
        last_reg       <= 1'b1;
        session_up_reg <= session_reg;
        kind_reg       <= rxrf_pkg::KIND_IDLE;
        if (cmd.store)
        begin
            kind_reg <= ring_full ? rxrf_pkg::KIND_DROPPED : rxrf_pkg::KIND_STORED;
        end
        else if (cmd.finish)
        begin
            priority if (tok_found_reg)
            begin
                kind_reg       <= session_reg ? rxrf_pkg::KIND_DISCONNECTED
                                              : rxrf_pkg::KIND_CONNECTED;
                session_up_reg <= !session_reg;
            end
            else if (eol_found_reg && !session_reg)
            begin
                kind_reg <= rxrf_pkg::KIND_DISCARDED;
            end
            else
            begin
                kind_reg <= rxrf_pkg::KIND_IDLE;
            end
        end
        else if (cmd.emit_out)
        begin
            kind_reg      <= rxrf_pkg::KIND_LINE_BYTE;
            line_byte_reg <= rd_data_reg;
            last_reg      <= emit_last;
        end
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign line_byte  = line_byte_reg;
    assign last       = last_reg;
    assign session_up = session_up_reg;

endmodule
